// ----- rtl/dbo_pkg.sv -----
// ----------------------------------------------------------------------------
// dbo_pkg: shared types and constants for the switch debouncer
// Item structs, request codes and position codes.
// ----------------------------------------------------------------------------
package dbo_pkg;

  // request codes
  localparam logic [1:0] REQ_POLL       = 2'd0;
  localparam logic [1:0] REQ_SLOW_TICK  = 2'd1;
  localparam logic [1:0] REQ_SET_FORCE  = 2'd2;
  localparam logic [1:0] REQ_CLR_FORCE  = 2'd3;

  // forced position codes
  localparam logic [1:0] POS_CLOSED     = 2'd0;
  localparam logic [1:0] POS_OPEN       = 2'd1;

  // settle count after reset
  localparam logic [3:0] SETTLE_RESET   = 4'd5;
  localparam logic [3:0] RUN_MAX        = 4'd15;

  typedef struct packed {
    logic [1:0] req_type;
    logic       pin_level;
    logic [1:0] forced_position;
    logic [7:0] forced_duration;
  } in_item_t;

  typedef struct packed {
    logic stable_position;
    logic stable_changed;
    logic override_on;
  } out_item_t;

endpackage

// ----- rtl/dbo_core.sv -----
// ----------------------------------------------------------------------------
// dbo_core: debounce and override state with its next-state logic
// Updates the state for one item on fire and gives that item's result.
// ----------------------------------------------------------------------------
module dbo_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  dbo_pkg::in_item_t item,
  input  logic [3:0]        settle_polls,
  output dbo_pkg::out_item_t result
);

  logic       stable_pos_r, stable_pos_nxt;
  logic       searching_r, searching_nxt;
  logic       cand_pos_r, cand_pos_nxt;
  logic [3:0] run_count_r, run_count_nxt;
  logic       force_active_r, force_active_nxt;
  logic       force_pos_r, force_pos_nxt;
  logic [7:0] force_rem_r, force_rem_nxt;
  logic       force_forever_r, force_forever_nxt;
  logic       changed;
  logic       cur;
  logic [3:0] run_inc;
  logic [7:0] rem_dec;

  assign cur     = force_active_r ? force_pos_r : item.pin_level;
  assign run_inc = (run_count_r < dbo_pkg::RUN_MAX) ? run_count_r + 4'd1 : run_count_r;
  assign rem_dec = force_rem_r - 8'd1;

  // next state for the item at hand
  always_comb begin
    stable_pos_nxt    = stable_pos_r;
    searching_nxt     = searching_r;
    cand_pos_nxt      = cand_pos_r;
    run_count_nxt     = run_count_r;
    force_active_nxt  = force_active_r;
    force_pos_nxt     = force_pos_r;
    force_rem_nxt     = force_rem_r;
    force_forever_nxt = force_forever_r;
    changed           = 1'b0;
    case (item.req_type)
      dbo_pkg::REQ_POLL: begin
        if (!searching_r) begin
          if (cur != stable_pos_r) begin
            cand_pos_nxt  = cur;
            searching_nxt = 1'b1;
            run_count_nxt = 4'd0;
          end
        end else if (cur == cand_pos_r) begin
          run_count_nxt = run_inc;
          if (run_inc >= settle_polls) begin
            if (stable_pos_r != cur) begin
              stable_pos_nxt = cur;
              changed        = 1'b1;
            end
            searching_nxt = 1'b0;
          end
        end else begin
          // bounce: restart the run on the new sample
          cand_pos_nxt  = cur;
          run_count_nxt = 4'd0;
        end
      end
      dbo_pkg::REQ_SLOW_TICK: begin
        if (!force_forever_r && (force_rem_r != 8'd0)) begin
          force_rem_nxt = rem_dec;
          if (rem_dec == 8'd0) force_active_nxt = 1'b0;
        end
      end
      dbo_pkg::REQ_SET_FORCE: begin
        // indeterminate position is ignored
        if (item.forced_position inside {dbo_pkg::POS_CLOSED, dbo_pkg::POS_OPEN}) begin
          force_forever_nxt = (item.forced_duration == 8'd0);
          force_rem_nxt     = item.forced_duration;
          force_pos_nxt     = item.forced_position[0];
          force_active_nxt  = 1'b1;
        end
      end
      dbo_pkg::REQ_CLR_FORCE: begin
        force_active_nxt = 1'b0;
      end
      default: begin
        force_active_nxt = force_active_r;
      end
    endcase
  end

  assign result.stable_position = stable_pos_nxt;
  assign result.stable_changed  = changed;
  assign result.override_on     = force_active_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_pos_r    <= 1'b0;
      searching_r     <= 1'b0;
      cand_pos_r      <= 1'b0;
      run_count_r     <= 4'd0;
      force_active_r  <= 1'b0;
      force_pos_r     <= 1'b0;
      force_rem_r     <= 8'd0;
      force_forever_r <= 1'b0;
    end else if (fire) begin
      stable_pos_r    <= stable_pos_nxt;
      searching_r     <= searching_nxt;
      cand_pos_r      <= cand_pos_nxt;
      run_count_r     <= run_count_nxt;
      force_active_r  <= force_active_nxt;
      force_pos_r     <= force_pos_nxt;
      force_rem_r     <= force_rem_nxt;
      force_forever_r <= force_forever_nxt;
    end
  end

endmodule

// ----- rtl/switch_debounce_with_override.sv -----
// An accepted item passes from the input register through the core update into the result register.
// Throughput: one item per cycle unless out_stall holds a full result register;
// the state update is a single pass of logic between the input and result registers.
// Reset (synchronous, rst_n low): position closed, no search, no override,
// settle count 5; both pipeline registers empty.
// ----------------------------------------------------------------------------
// switch_debounce_with_override: handle switch debouncer with forced override
// Input register, debounce/override update, result register.
// ----------------------------------------------------------------------------
module switch_debounce_with_override (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dbo_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output dbo_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);

  logic               s1_valid_r;
  dbo_pkg::in_item_t  s1_item_r;
  logic               out_valid_r;
  dbo_pkg::out_item_t out_item_r;
  dbo_pkg::out_item_t result;
  logic [3:0]         settle_polls_r;
  logic               advance;
  logic               fire;

  // output register free or draining this cycle
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign cfg_ready = 1'b1;

  // settle count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_polls_r <= dbo_pkg::SETTLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      settle_polls_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  dbo_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .item         (s1_item_r),
    .settle_polls (settle_polls_r),
    .result       (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
